>>> design/hsl2rgb_pkg.sv
// Shared widths, constants and hue helpers for the HSL to RGBA8 converter.
package hsl2rgb_pkg;

    localparam int HUE_W  = 11;  // hue position, 1536 steps per turn
    localparam int FRAC_W = 13;  // fractions with 12 fraction bits
    localparam int CH_W   = 8;   // one output channel
    localparam int K_W    = 9;   // ramp step, 0..256
    localparam int PQ_W   = 28;  // signed p, q and q - p, 24 fraction bits
    localparam int V_W    = 37;  // signed ramp value, 32 fraction bits

    localparam logic [HUE_W-1:0]  HueTurn  = 11'd1536;
    localparam logic [HUE_W-1:0]  HueSixth = 11'd256;
    localparam logic [FRAC_W-1:0] FracOne  = 13'd4096;
    localparam logic [FRAC_W-1:0] FracHalf = 13'd2048;

    // Wrap a sum of a hue and an offset back into one turn.
    function automatic logic [HUE_W-1:0] hue_wrap(input logic [HUE_W:0] t);
        logic [HUE_W:0] w;
        begin
            w = t - {1'b0, HueTurn};
            hue_wrap = (t >= {1'b0, HueTurn}) ? w[HUE_W-1:0] : t[HUE_W-1:0];
        end
    endfunction

    // Number of steps from p toward q at hue position t (0..256).
    function automatic logic [K_W-1:0] hue_step(input logic [HUE_W-1:0] t);
        logic [HUE_W-1:0] fall;
        begin
            fall = (HueSixth << 2) - t;
            if (t < HueSixth) begin
                hue_step = K_W'(t);
            end else if (t < 3 * HueSixth) begin
                hue_step = K_W'(HueSixth);
            end else if (t < (HueSixth << 2)) begin
                hue_step = K_W'(fall);
            end else begin
                hue_step = '0;
            end
        end
    endfunction

endpackage

>>> design/hsl2rgb_chan.sv
// One color channel: ramp multiply, ramp sum and rounding to eight bits.
module hsl2rgb_chan
    import hsl2rgb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   en,       // pipeline advance
    input  logic signed [PQ_W-1:0] p_in,     // p, 24 fraction bits
    input  logic signed [PQ_W-1:0] d_in,     // q - p, 24 fraction bits
    input  logic [K_W-1:0]         k_in,     // steps along the ramp
    output logic [CH_W-1:0]        chan_out
);

    logic signed [PQ_W+K_W:0] prod_full;
    logic signed [V_W-1:0]    prod_next, prod_reg;
    logic signed [V_W-1:0]    base_next, base_reg;
    logic signed [V_W-1:0]    v_next, v_reg;
    logic [V_W+7:0]           n_scaled;
    logic [V_W+7:0]           n_round;
    logic [V_W-25:0]          r_whole;
    logic [CH_W-1:0]          chan_next, chan_reg;

    // Stage A: (q - p) * k, and 256 * p alongside.
    assign prod_full = d_in * $signed({1'b0, k_in});
    assign prod_next = V_W'(prod_full);
    assign base_next = V_W'(p_in) <<< 8;

    // Stage B: ramp value with 32 fraction bits.
    assign v_next = base_reg + prod_reg;

    // Stage C: scale by 255, round half up, saturate; non-positive gives zero.
    assign n_scaled = {v_reg[V_W-1:0], 8'd0} - {8'd0, v_reg[V_W-1:0]};
    assign n_round  = n_scaled + ((V_W+8)'(1) << 31);
    assign r_whole  = n_round[V_W+7:32];

    always_comb begin
        if (v_reg <= 0) begin
            chan_next = '0;
        end else if (|r_whole[V_W-25:CH_W]) begin
            chan_next = '1;
        end else begin
            chan_next = r_whole[CH_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            base_reg <= base_next;
            v_reg    <= v_next;
            chan_reg <= chan_next;
        end
    end

    assign chan_out = chan_reg;

endmodule

>>> design/hsl_to_rgba8_convert_top.sv
// Top level of the HSL to RGBA8 pixel converter.
//
//  Channel | Direction | Ports                          | tdata fields, lowest bit first
//  --------+-----------+--------------------------------+------------------------------------
//  input   | in        | s_tvalid, s_tready, s_tdata    | hue[10:0], saturation[23:11],
//          |           |                                | lightness[36:24], alpha_in[49:37]
//  result  | out       | m_tvalid, m_tready, m_tdata    | red[7:0], green[15:8], blue[23:16],
//          |           |                                | alpha_out[31:24]
//
// Five-stage pipeline, one item per cycle while no stall on m_tready holds it. Stage one
// wraps the hue and forms the ramp steps, q and the rounded alpha; stage two forms p and
// q - p; stages three to five run the per-channel ramp multiply, ramp sum and rounding,
// with alpha delayed to match. Reset clears the valid bits only, so the pipeline comes up
// empty. A stall on m_tready freezes every stage at once and s_tready follows it, so no
// item is dropped or repeated.
module hsl_to_rgba8_convert_top
    import hsl2rgb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // hue, saturation, lightness, alpha_in, zero fill

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // red, green, blue, alpha_out
);

    localparam int NSTAGE = 5;

    // Unpacked input fields.
    logic [HUE_W-1:0]  hue;
    logic [FRAC_W-1:0] sat;
    logic [FRAC_W-1:0] light;
    logic [FRAC_W-1:0] alpha_in;

    assign hue      = s_tdata[10:0];
    assign sat      = s_tdata[23:11];
    assign light    = s_tdata[36:24];
    assign alpha_in = s_tdata[49:37];

    // The whole pipeline moves together whenever the last stage is empty or being taken.
    logic pipe_en;
    logic [NSTAGE-1:0] vld_reg, vld_next;

    assign pipe_en  = !vld_reg[NSTAGE-1] || m_tready;
    assign s_tready = pipe_en;
    assign vld_next = {vld_reg[NSTAGE-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= vld_next;
        end
    end

    // Stage one: hue positions for each channel, ramp steps, q and rounded alpha.
    logic [HUE_W-1:0] hue_g, hue_r, hue_b;
    logic [K_W-1:0]   kr_next, kg_next, kb_next;
    logic [K_W-1:0]   kr_reg, kg_reg, kb_reg;

    assign hue_g   = hue_wrap({1'b0, hue});
    assign hue_r   = hue_wrap({1'b0, hue_g} + {1'b0, HueSixth << 1});
    assign hue_b   = hue_wrap({1'b0, hue_g} + {1'b0, HueSixth << 2});
    assign kr_next = hue_step(hue_r);
    assign kg_next = hue_step(hue_g);
    assign kb_next = hue_step(hue_b);

    // q = l*4096 + s*m, where m is l below one half and 4096 - l otherwise.
    logic signed [FRAC_W:0]     mult_m;
    logic signed [2*FRAC_W:0]   sm_prod;
    logic signed [PQ_W-1:0]     q_next, q_reg;
    logic [FRAC_W-1:0]          light_reg;

    assign mult_m  = (light < FracHalf) ? $signed({1'b0, light})
                                        : $signed({1'b0, FracOne}) - $signed({1'b0, light});
    assign sm_prod = $signed({1'b0, sat}) * mult_m;
    assign q_next  = (PQ_W'($signed({1'b0, light})) <<< 12) + PQ_W'(sm_prod);

    // Alpha: round(a*255/4096) half up, saturated to 255.
    logic [FRAC_W+7:0] a_scaled;
    logic [8:0]        a_whole;
    logic [CH_W-1:0]   alpha_next;
    logic [CH_W-1:0]   alpha_pipe_reg [NSTAGE];

    assign a_scaled   = {alpha_in, 8'd0} - {8'd0, alpha_in} + (FRAC_W+8)'(FracHalf);
    assign a_whole    = a_scaled[FRAC_W+7:12];
    assign alpha_next = a_whole[8] ? '1 : a_whole[CH_W-1:0];

    // Stage two: p = 2*l*4096 - q and q - p = 2*q - 2*l*4096.
    logic signed [PQ_W-1:0] l2_scaled;
    logic signed [PQ_W-1:0] p_next, p_reg;
    logic signed [PQ_W-1:0] d_next, d_reg;
    logic [K_W-1:0]         kr2_reg, kg2_reg, kb2_reg;

    assign l2_scaled = PQ_W'($signed({1'b0, light_reg})) <<< 13;
    assign p_next    = l2_scaled - q_reg;
    assign d_next    = (q_reg <<< 1) - l2_scaled;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            kr_reg    <= kr_next;
            kg_reg    <= kg_next;
            kb_reg    <= kb_next;
            q_reg     <= q_next;
            light_reg <= light;
            p_reg     <= p_next;
            d_reg     <= d_next;
            kr2_reg   <= kr_reg;
            kg2_reg   <= kg_reg;
            kb2_reg   <= kb_reg;
            alpha_pipe_reg[0] <= alpha_next;
            for (int i = 1; i < NSTAGE; i++) begin
                alpha_pipe_reg[i] <= alpha_pipe_reg[i-1];
            end
        end
    end

    // Stages three to five: one ramp unit per color channel.
    logic [CH_W-1:0] red, green, blue;

    hsl2rgb_chan u_chan_red (
        .aclk     (aclk),
        .en       (pipe_en),
        .p_in     (p_reg),
        .d_in     (d_reg),
        .k_in     (kr2_reg),
        .chan_out (red)
    );

    hsl2rgb_chan u_chan_green (
        .aclk     (aclk),
        .en       (pipe_en),
        .p_in     (p_reg),
        .d_in     (d_reg),
        .k_in     (kg2_reg),
        .chan_out (green)
    );

    hsl2rgb_chan u_chan_blue (
        .aclk     (aclk),
        .en       (pipe_en),
        .p_in     (p_reg),
        .d_in     (d_reg),
        .k_in     (kb2_reg),
        .chan_out (blue)
    );

    assign m_tvalid = vld_reg[NSTAGE-1];
    assign m_tdata  = {alpha_pipe_reg[NSTAGE-1], blue, green, red};

endmodule
